>>> rtl/qat_pkg.sv
// Shared types, character codes and sizes for the quoted argument tokenizer.
package qat_pkg;

  localparam int unsigned LINE_COUNT_BITS = 16;
  localparam int unsigned MAX_TOKENS      = 4;
  localparam int unsigned TOK_IDX_W       = $clog2(MAX_TOKENS);
  localparam int unsigned TOK_CNT_W       = $clog2(MAX_TOKENS + 1);
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_END_ARG   = 3'd1,
    KIND_END_CMD   = 3'd2,
    KIND_QUOTE_ERR = 3'd3,
    KIND_FINISHED  = 3'd4
  } token_kind_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    token_kind_e                token_kind;
    logic [7:0]                 out_char;
    logic [LINE_COUNT_BITS-1:0] line_count;
    logic                       last_of_run;
  } out_item_t;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  chr;
  } token_t;

  // All results caused by one input item; they share one line count.
  typedef struct packed {
    logic [TOK_CNT_W-1:0]       cnt;
    token_t [MAX_TOKENS-1:0]    tok;
    logic [LINE_COUNT_BITS-1:0] line;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/qat_front.sv
// Front end: accepts text bytes, tracks quoting state and builds the run of tokens per byte.
module qat_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  qat_pkg::in_item_t    in_data_i,
  input  qat_pkg::q_status_t   q_status_i,
  output logic                 push_o,
  output qat_pkg::run_t        run_o
);

  typedef struct packed {
    logic                                pe;  // pending escape
    logic                                ic;  // in comment
    logic                                dq;  // in double quotes
    logic                                sq;  // in single quotes
    logic                                ao;  // argument open
    logic                                ca;  // command has args
    logic                                eh;  // error halted
    logic [qat_pkg::LINE_COUNT_BITS-1:0] nl;  // newline total
  } state_t;

  typedef struct packed {
    state_t        st;
    qat_pkg::run_t run;
  } scan_t;

  state_t st_q, st_d;
  scan_t  scan;
  logic   accept;
  logic   quoted;
  logic [7:0] ch;

  function automatic scan_t add_tok(scan_t s, qat_pkg::token_kind_e k, logic [7:0] c);
    scan_t r;
    r = s;
    r.run.tok[s.run.cnt[qat_pkg::TOK_IDX_W-1:0]].kind = k;
    r.run.tok[s.run.cnt[qat_pkg::TOK_IDX_W-1:0]].chr  = c;
    r.run.cnt = s.run.cnt + qat_pkg::TOK_CNT_W'(1);
    return r;
  endfunction

  function automatic scan_t put_char(scan_t s, logic [7:0] c);
    scan_t r;
    r = add_tok(s, qat_pkg::KIND_CHAR, c);
    r.st.ao = 1'b1;
    return r;
  endfunction

  // A pending escape flushes as a lone backslash before the argument ends.
  function automatic scan_t close_arg(scan_t s);
    scan_t r;
    r = s;
    if (r.st.ao || r.st.pe) begin
      if (r.st.pe) begin
        r = add_tok(r, qat_pkg::KIND_CHAR, qat_pkg::CH_BSLASH);
        r.st.pe = 1'b0;
      end
      r = add_tok(r, qat_pkg::KIND_END_ARG, 8'h00);
      r.st.ao = 1'b0;
      r.st.ca = 1'b1;
    end
    return r;
  endfunction

  // Empty commands send nothing.
  function automatic scan_t send_cmd(scan_t s);
    scan_t r;
    r = close_arg(s);
    if (r.st.ca) begin
      r = add_tok(r, qat_pkg::KIND_END_CMD, 8'h00);
      r.st.ca = 1'b0;
    end
    return r;
  endfunction

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign ch         = in_data_i.text_byte;
  assign quoted     = st_q.dq || st_q.sq;

  always_comb begin
    scan.st  = st_q;
    scan.run = '0;
    if (in_data_i.end_of_input) begin
      if (!st_q.eh) begin
        if (quoted) begin
          scan = add_tok(scan, qat_pkg::KIND_QUOTE_ERR, 8'h00);
        end else begin
          scan = send_cmd(scan);
        end
      end
      scan = add_tok(scan, qat_pkg::KIND_FINISHED, 8'h00);
    end else if (st_q.eh) begin
      // drop text until end of input
      scan.st = st_q;
    end else if (ch == qat_pkg::CH_LF || ch == qat_pkg::CH_CR) begin
      scan.st.ic = 1'b0;
      if (!st_q.pe && quoted) begin
        scan = add_tok(scan, qat_pkg::KIND_QUOTE_ERR, 8'h00);
        scan.st.eh = 1'b1;
      end else begin
        if (st_q.nl != '1) begin
          scan.st.nl = st_q.nl + qat_pkg::LINE_COUNT_BITS'(1);
        end
        if (st_q.pe) begin
          scan.st.pe = 1'b0;
        end else begin
          scan = send_cmd(scan);
        end
      end
    end else if (st_q.ic) begin
      // skip comment text
      scan.st = st_q;
    end else if (st_q.pe) begin
      scan = put_char(scan, qat_pkg::CH_BSLASH);
      scan = put_char(scan, ch);
      scan.st.pe = 1'b0;
    end else if (!quoted && ch == qat_pkg::CH_SEMI) begin
      scan = send_cmd(scan);
    end else if (!quoted && ch == qat_pkg::CH_HASH) begin
      scan.st.ic = 1'b1;
    end else if (!quoted && (ch == qat_pkg::CH_SPACE || ch == qat_pkg::CH_TAB)) begin
      scan = close_arg(scan);
    end else if (!quoted && ch == qat_pkg::CH_BSLASH) begin
      scan.st.pe = 1'b1;
    end else if (!st_q.sq && ch == qat_pkg::CH_DQUOTE) begin
      scan.st.dq = !st_q.dq;
    end else if (!st_q.dq && ch == qat_pkg::CH_SQUOTE) begin
      scan.st.sq = !st_q.sq;
    end else begin
      scan = put_char(scan, ch);
    end
    scan.run.line = scan.st.nl;
    // end of input returns everything to the reset state
    st_d = in_data_i.end_of_input ? '0 : scan.st;
  end

  assign push_o = accept && (scan.run.cnt != '0);
  assign run_o  = scan.run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  a_quotes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.dq && st_q.sq))
    else $error("double and single quotes open together");

  a_comment_unquoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ic |-> !(st_q.dq || st_q.sq))
    else $error("comment state inside quotes");

endmodule

>>> rtl/qat_fifo.sv
// Short queue of token runs between the front and back ends.
module qat_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qat_pkg::run_t       push_data_i,
  input  logic                pop_i,
  output qat_pkg::q_status_t  status_o,
  output qat_pkg::run_t       head_o
);

  localparam int unsigned PTR_W = (qat_pkg::QUEUE_DEPTH > 1) ? $clog2(qat_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(qat_pkg::QUEUE_DEPTH + 1);

  qat_pkg::run_t        mem_q [qat_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNT_W'(qat_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(qat_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(qat_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

endmodule

>>> rtl/qat_back.sv
// Back end: walks each queued run and sends its tokens one beat at a time.
module qat_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qat_pkg::q_status_t  q_status_i,
  input  qat_pkg::run_t       head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qat_pkg::out_item_t  out_data_o
);

  logic [qat_pkg::TOK_IDX_W-1:0] idx_q;
  logic                          out_valid_q;
  qat_pkg::out_item_t            out_q;
  logic                          slot_free;
  logic                          load;
  logic                          last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = slot_free && !q_status_i.empty;
  assign last      = (qat_pkg::TOK_CNT_W'(idx_q) + qat_pkg::TOK_CNT_W'(1)) == head_i.cnt;
  assign pop_o     = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (slot_free) begin
        out_valid_q <= !q_status_i.empty;
      end
      if (load) begin
        idx_q <= last ? '0 : idx_q + qat_pkg::TOK_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.token_kind  <= head_i.tok[idx_q].kind;
      out_q.out_char    <= head_i.tok[idx_q].chr;
      out_q.line_count  <= head_i.line;
      out_q.last_of_run <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> (qat_pkg::TOK_CNT_W'(idx_q) < head_i.cnt))
    else $error("token index past end of run");

  a_finished_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.token_kind == qat_pkg::KIND_FINISHED) |-> out_q.last_of_run)
    else $error("finished token not last of its run");

endmodule

>>> rtl/quoted_argument_tokenizer.sv
// Top level of the quoted argument tokenizer: front end, run queue and back end.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (text byte, eof)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (token, line, last)
//
// The front end takes one byte per cycle while the two-entry run queue has room.
// Each byte yields zero to four tokens; the back end sends one token per cycle while
// out_ready_i is high, so bytes with several tokens slow the input.
// A byte's first token passes through the run queue and the output register before it appears.
// Reset clears the quoting state, line count, queue and output valid flag.
// Output stalls back up through the queue into in_ready_o; bytes with no tokens
// still pass whenever the queue is not full.
module quoted_argument_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qat_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qat_pkg::out_item_t  out_data_o
);

  qat_pkg::q_status_t q_status;
  qat_pkg::run_t      push_run;
  qat_pkg::run_t      head_run;
  logic               push;
  logic               pop;

  qat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .run_o      (push_run)
  );

  qat_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_run),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (head_run)
  );

  qat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (head_run),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the quoted argument tokenizer with bursty input and stalled output.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct packed {
    qat_pkg::in_item_t item;
    logic              drain_first;
  } stim_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_SELDOM,
    RDY_TOGGLE
  } ready_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  qat_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  qat_pkg::out_item_t out_data_o;

  stim_t              text_queue[$];
  qat_pkg::out_item_t run_tokens[$];
  qat_pkg::out_item_t expected_tokens[$];
  qat_pkg::out_item_t want_tok;

  // Tokenizer state mirrored by the predictor.
  logic                                esc_pending  = 1'b0;
  logic                                in_comment   = 1'b0;
  logic                                in_dq        = 1'b0;
  logic                                in_sq        = 1'b0;
  logic                                arg_open     = 1'b0;
  logic                                cmd_has_args = 1'b0;
  logic                                halted       = 1'b0;
  logic [qat_pkg::LINE_COUNT_BITS-1:0] line_total   = '0;

  logic        byte_accepted = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned tokens_seen   = 0;
  int unsigned mismatches    = 0;
  int unsigned burst_left    = 8;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  logic        held_once     = 1'b0;
  ready_mode_e ready_mode    = RDY_ALWAYS;

  quoted_argument_tokenizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic note_token(input qat_pkg::token_kind_e kind, input logic [7:0] chr);
    qat_pkg::out_item_t tok;
    tok.token_kind  = kind;
    tok.out_char    = chr;
    tok.line_count  = line_total;
    tok.last_of_run = 1'b0;
    run_tokens.push_back(tok);
  endtask

  task automatic add_arg_char(input logic [7:0] chr);
    note_token(qat_pkg::KIND_CHAR, chr);
    arg_open = 1'b1;
  endtask

  task automatic finish_word();
    if (arg_open || esc_pending) begin
      // A dangling escape goes out as a lone backslash.
      if (esc_pending) begin
        note_token(qat_pkg::KIND_CHAR, qat_pkg::CH_BSLASH);
        esc_pending = 1'b0;
      end
      note_token(qat_pkg::KIND_END_ARG, 8'h00);
      arg_open     = 1'b0;
      cmd_has_args = 1'b1;
    end
  endtask

  task automatic finish_command();
    finish_word();
    if (cmd_has_args) begin
      note_token(qat_pkg::KIND_END_CMD, 8'h00);
      cmd_has_args = 1'b0;
    end
  endtask

  task automatic predict_tokens(input qat_pkg::in_item_t item);
    logic [7:0]         c;
    logic               quoted;
    qat_pkg::out_item_t tok;
    c      = item.text_byte;
    quoted = in_dq || in_sq;
    if (item.end_of_input) begin
      if (!halted) begin
        if (quoted) note_token(qat_pkg::KIND_QUOTE_ERR, 8'h00);
        else finish_command();
      end
      note_token(qat_pkg::KIND_FINISHED, 8'h00);
      esc_pending  = 1'b0;
      in_comment   = 1'b0;
      in_dq        = 1'b0;
      in_sq        = 1'b0;
      arg_open     = 1'b0;
      cmd_has_args = 1'b0;
      halted       = 1'b0;
      line_total   = '0;
    end else if (halted) begin
      // drop text until end of input
    end else if (c == qat_pkg::CH_LF || c == qat_pkg::CH_CR) begin
      in_comment = 1'b0;
      if (!esc_pending && quoted) begin
        note_token(qat_pkg::KIND_QUOTE_ERR, 8'h00);
        halted = 1'b1;
      end else begin
        if (line_total != '1) line_total = line_total + 1'b1;
        if (esc_pending) esc_pending = 1'b0;
        else finish_command();
      end
    end else if (in_comment) begin
      // skip comment text
    end else if (esc_pending) begin
      add_arg_char(qat_pkg::CH_BSLASH);
      add_arg_char(c);
      esc_pending = 1'b0;
    end else if (!quoted && c == qat_pkg::CH_SEMI) begin
      finish_command();
    end else if (!quoted && c == qat_pkg::CH_HASH) begin
      in_comment = 1'b1;
    end else if (!quoted && (c == qat_pkg::CH_SPACE || c == qat_pkg::CH_TAB)) begin
      finish_word();
    end else if (!quoted && c == qat_pkg::CH_BSLASH) begin
      esc_pending = 1'b1;
    end else if (!in_sq && c == qat_pkg::CH_DQUOTE) begin
      in_dq = ~in_dq;
    end else if (!in_dq && c == qat_pkg::CH_SQUOTE) begin
      in_sq = ~in_sq;
    end else begin
      add_arg_char(c);
    end
    for (int i = 0; i < run_tokens.size(); i++) begin
      tok             = run_tokens[i];
      tok.last_of_run = (i == run_tokens.size() - 1);
      expected_tokens.push_back(tok);
    end
    run_tokens.delete();
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(input logic [7:0] b, input logic eoi, input logic drain);
    stim_t s;
    s.item.text_byte    = b;
    s.item.end_of_input = eoi;
    s.drain_first       = drain;
    text_queue.push_back(s);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(b, 1'b0, 1'b0);
  endtask

  task automatic add_eoi(input logic drain);
    push_item(8'($urandom_range(0, 255)), 1'b1, drain);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 2) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(8'h61, 8'h7A));
    end while (b == qat_pkg::CH_SEMI || b == qat_pkg::CH_HASH || b == qat_pkg::CH_SPACE ||
               b == qat_pkg::CH_TAB || b == qat_pkg::CH_LF || b == qat_pkg::CH_CR ||
               b == qat_pkg::CH_DQUOTE || b == qat_pkg::CH_SQUOTE ||
               b == qat_pkg::CH_BSLASH);
    return b;
  endfunction

  task automatic add_quoted(input logic [7:0] q, input logic closed);
    int unsigned n;
    logic [7:0]  b;
    push_byte(q);
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       b = qat_pkg::CH_SPACE;
        1:       b = qat_pkg::CH_SEMI;
        2:       b = qat_pkg::CH_HASH;
        3:       b = qat_pkg::CH_BSLASH;
        4:       b = (q == qat_pkg::CH_DQUOTE) ? qat_pkg::CH_SQUOTE : qat_pkg::CH_DQUOTE;
        5:       b = qat_pkg::CH_TAB;
        default: b = plain_char();
      endcase
      push_byte(b);
    end
    if (closed) push_byte(q);
  endtask

  task automatic add_word();
    int unsigned pieces;
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      case ($urandom_range(0, 5))
        0: add_quoted(qat_pkg::CH_DQUOTE, 1'b1);
        1: add_quoted(qat_pkg::CH_SQUOTE, 1'b1);
        2: begin
          // escape any byte, line ends included
          push_byte(qat_pkg::CH_BSLASH);
          push_byte(($urandom_range(0, 3) == 0) ? qat_pkg::CH_LF
                                                : 8'($urandom_range(0, 255)));
        end
        default: repeat ($urandom_range(1, 4)) push_byte(plain_char());
      endcase
    end
  endtask

  task automatic add_separator();
    repeat ($urandom_range(1, 2)) begin
      push_byte(($urandom_range(0, 1) != 0) ? qat_pkg::CH_SPACE : qat_pkg::CH_TAB);
    end
  endtask

  task automatic add_command();
    int unsigned nargs;
    nargs = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) add_separator();
    for (int i = 0; i < nargs; i++) begin
      add_word();
      if (i + 1 < nargs || $urandom_range(0, 3) == 0) add_separator();
    end
    case ($urandom_range(0, 5))
      0: push_byte(qat_pkg::CH_SEMI);
      1: push_byte(qat_pkg::CH_CR);
      2: begin
        push_byte(qat_pkg::CH_CR);
        push_byte(qat_pkg::CH_LF);
      end
      3: begin
        push_byte(qat_pkg::CH_HASH);
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
        push_byte(qat_pkg::CH_LF);
      end
      default: push_byte(qat_pkg::CH_LF);
    endcase
  endtask

  initial begin
    int unsigned r;
    // directed: extreme bytes, separators, quoting, escapes, comments, errors
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h61);
    push_byte(qat_pkg::CH_TAB);
    push_byte(qat_pkg::CH_DQUOTE);
    push_byte(qat_pkg::CH_DQUOTE);
    push_byte(qat_pkg::CH_BSLASH);
    push_byte(8'h78);
    push_byte(qat_pkg::CH_BSLASH);
    push_byte(qat_pkg::CH_LF);
    push_byte(qat_pkg::CH_SQUOTE);
    push_byte(qat_pkg::CH_SEMI);
    push_byte(qat_pkg::CH_SQUOTE);
    push_byte(qat_pkg::CH_SPACE);
    push_byte(qat_pkg::CH_HASH);
    push_byte(8'h7A);
    push_byte(qat_pkg::CH_CR);
    push_byte(qat_pkg::CH_SEMI);
    push_byte(qat_pkg::CH_DQUOTE);
    push_byte(qat_pkg::CH_LF);
    push_byte(8'h71);
    add_eoi(1'b0);
    push_byte(qat_pkg::CH_SQUOTE);
    add_eoi(1'b0);
    push_byte(qat_pkg::CH_BSLASH);
    add_eoi(1'b1);

    while (text_queue.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_command();
      end else if (r < 88) begin
        add_eoi($urandom_range(0, 2) == 0);
      end else if (r < 94) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        // open quote broken by a line end, then junk until end of input
        add_quoted(($urandom_range(0, 1) != 0) ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE,
                   1'b0);
        push_byte(($urandom_range(0, 1) != 0) ? qat_pkg::CH_LF : qat_pkg::CH_CR);
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        add_eoi(1'b0);
      end
    end
    add_eoi(1'b1);
  end

  // ---------------------------------------------------------------- reset and driver

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_accepted)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (text_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (text_queue[0].drain_first && expected_tokens.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= text_queue[0].item;
        void'(text_queue.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          if ($urandom_range(0, 2) == 0) gap_left <= 0;
          else if ($urandom_range(0, 9) == 0) gap_left <= $urandom_range(10, 30);
          else gap_left <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!held_once && tokens_seen >= 120) begin
      // one long hold-off so the run queue fills and backs up the input
      held_once   <= 1'b1;
      hold_left   <= 400;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        RDY_SELDOM: out_ready_i <= ($urandom_range(0, 2) == 0);
        default:    out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d tokens outstanding", $time, expected_tokens.size());
      $display("FAILED: results differ");
      $finish;
    end
    byte_accepted = rst_ni && in_valid_i && in_ready_o;
    if (byte_accepted) predict_tokens(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d char %0d line %0d",
                 $time, out_data_o.token_kind, out_data_o.out_char, out_data_o.line_count);
        mismatches++;
      end else begin
        want_tok = expected_tokens.pop_front();
        report_field("token_kind", want_tok.token_kind, out_data_o.token_kind);
        report_field("out_char", want_tok.out_char, out_data_o.out_char);
        report_field("line_count", want_tok.line_count, out_data_o.line_count);
        report_field("last_of_run", want_tok.last_of_run, out_data_o.last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------- end of run

  initial begin
    @(posedge rst_ni);
    do @(posedge clk_i);
    while (text_queue.size() != 0 || in_valid_i || expected_tokens.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
